// ----- rtl/pol_pkg.sv -----
// Shared types and constants for the positional ordered list.
package pol_pkg;

	// Width of one stored entry and of the result value.
	localparam int DATA_W = 32;
	// Slot index width, wide enough for the largest supported list of 64 entries.
	localparam int SLOT_W = 6;

	// Command codes carried on the input stream.
	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_POS   = 3'd1,
		ACT_INS_END   = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_POS   = 3'd4,
		ACT_DEL_END   = 3'd5,
		ACT_DUMP      = 3'd6
	} action_t;

	// Status codes reported with every result.
	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_FULL   = 2'd2,
		STS_BADPOS = 2'd3
	} status_t;

	// Operations applied to every cell of the chain in the same cycle.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_ROTATE = 2'd3
	} chain_op_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} ctrl_state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		chain_op_t           op;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   tail;
		logic [DATA_W-1:0]   value;
	} chain_cmd_t;

endpackage

// ----- rtl/pol_cell.sv -----
// One storage cell of the list chain, holding the entry at a fixed slot.
module pol_cell import pol_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  chain_cmd_t        cmd,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	input  logic [DATA_W-1:0] head_data,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] hit
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	// Choose the new content from the broadcast command and the neighbours.
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			OP_INSERT: begin
				if (MY_SLOT == cmd.slot) begin
					data_d = cmd.value;
				end else if (MY_SLOT > cmd.slot) begin
					data_d = left_data;
				end
			end
			OP_REMOVE: begin
				if (MY_SLOT >= cmd.slot) begin
					data_d = right_data;
				end
			end
			OP_ROTATE: begin
				if (MY_SLOT < cmd.tail) begin
					data_d = right_data;
				end else if (MY_SLOT == cmd.tail) begin
					data_d = head_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Entry storage; contents are meaningful only below the fill count.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	// Contribute the entry to the read bus only when this slot is addressed.
	assign hit  = (MY_SLOT == cmd.slot) ? data_q : '0;

endmodule

// ----- rtl/pol_chain.sv -----
// Row of list cells with the selected-entry read bus.
module pol_chain import pol_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  chain_cmd_t        cmd,
	output logic [DATA_W-1:0] head_data,
	output logic [DATA_W-1:0] hit_data
);

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_hit  [CAPACITY];

	// Each cell sees its left and right neighbour and the head of the list.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_inner_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_d = cell_data[i+1];
		end

		pol_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  (left_d),
			.right_data (right_d),
			.head_data  (cell_data[0]),
			.data       (cell_data[i]),
			.hit        (cell_hit[i])
		);
	end

	// Only the addressed cell drives a non-zero word, so an OR merges them.
	always_comb begin
		hit_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_data = hit_data | cell_hit[i];
		end
	end

	assign head_data = cell_data[0];

endmodule

// ----- rtl/pol_ctrl.sv -----
// Command decoder, fill count, dump sequencer and result register.
module pol_ctrl import pol_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [SLOT_W-1:0] position,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_value,
	output logic [1:0]        out_status,
	output logic              out_last,
	output chain_cmd_t        cmd,
	input  logic [DATA_W-1:0] head_data,
	input  logic [DATA_W-1:0] hit_data
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     dump_q;
	logic [CW-1:0]     dump_d;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           out_status_q;
	logic              out_last_q;

	logic              out_free;
	logic              in_fire;
	logic              out_load;
	logic [DATA_W-1:0] ld_value;
	status_t           ld_status;
	logic              ld_last;
	logic              is_full;
	logic              is_empty;
	logic              bad_ins;
	logic              bad_del;
	logic              dump_last;
	logic [CMPW-1:0]   pos_w;
	logic [CMPW-1:0]   cnt_w;
	action_t           act;

	// Handshake and list condition flags.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign act       = action_t'(action);
	assign is_full   = (count_q == CW'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign pos_w     = CMPW'(position);
	assign cnt_w     = CMPW'(count_q);
	assign bad_ins   = (position == '0) || (pos_w > cnt_w + CMPW'(1));
	assign bad_del   = (position == '0) || (pos_w > cnt_w);
	assign dump_last = (dump_q == count_q - CW'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && act == ACT_DUMP && !is_empty) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (out_free && dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Chain command, count update and result loading.
	always_comb begin
		cmd.op    = OP_HOLD;
		cmd.slot  = '0;
		cmd.tail  = SLOT_W'(count_q - CW'(1));
		cmd.value = value;
		count_d   = count_q;
		dump_d    = dump_q;
		out_load  = 1'b0;
		ld_value  = '0;
		ld_status = STS_OK;
		ld_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (act)
						ACT_INS_FRONT, ACT_INS_POS, ACT_INS_END: begin
							out_load = 1'b1;
							if (is_full) begin
								ld_status = STS_FULL;
							end else if (act == ACT_INS_POS && bad_ins) begin
								ld_status = STS_BADPOS;
							end else begin
								cmd.op  = OP_INSERT;
								count_d = count_q + CW'(1);
								if (act == ACT_INS_END) begin
									cmd.slot = SLOT_W'(count_q);
								end else if (act == ACT_INS_POS) begin
									cmd.slot = position - SLOT_W'(1);
								end
							end
						end
						ACT_DEL_FRONT, ACT_DEL_POS, ACT_DEL_END: begin
							out_load = 1'b1;
							if (act == ACT_DEL_END) begin
								cmd.slot = SLOT_W'(count_q - CW'(1));
							end else if (act == ACT_DEL_POS) begin
								cmd.slot = position - SLOT_W'(1);
							end
							if (is_empty) begin
								ld_status = STS_EMPTY;
							end else if (act == ACT_DEL_POS && bad_del) begin
								ld_status = STS_BADPOS;
							end else begin
								cmd.op   = OP_REMOVE;
								ld_value = hit_data;
								count_d  = count_q - CW'(1);
							end
						end
						ACT_DUMP: begin
							dump_d = '0;
							if (is_empty) begin
								out_load  = 1'b1;
								ld_status = STS_EMPTY;
							end
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					// Emit the head and rotate the occupied cells by one.
					out_load = 1'b1;
					ld_value = head_data;
					ld_last  = dump_last;
					cmd.op   = OP_ROTATE;
					dump_d   = dump_q + CW'(1);
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dump_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			dump_q  <= dump_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= ld_value;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

`ifndef SYNTHESIS
	// The fill count never passes the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");

	// No command is taken while a dump is running.
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> !in_ready)
		else $error("input taken during dump");

	// A successful insert grows the list by exactly one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INSERT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	// A successful delete shrinks the list by exactly one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_REMOVE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not shrink the list");
`endif

endmodule

// ----- rtl/positional_ordered_list_core.sv -----
// Top level of the positional ordered list with stream command and result ports.
//
// A bounded ordered list of up to CAPACITY signed 32-bit entries, held in a row
// of cells that shift towards or away from the addressed slot. Each command
// transfer inserts at the front, the end or a 1-based position, deletes at one
// of those places and returns the removed value, or dumps the list front to
// back with tlast on the final result. Inserts, deletes and error cases each
// give one result; a dump gives one result per entry, read from the head
// cell while the occupied cells rotate by one as each result is loaded, so an
// output stall also holds the rotation. A new command is taken once the
// controller is idle and the result register is empty or being drained. No
// clearing pass is needed after reset.
module positional_ordered_list_core import pol_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [5:0] position, [37:6] value, [39:38] zero
	input  logic [2:0]  s_tuser,  // [2:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] item_value
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic        m_tlast
);

	chain_cmd_t        cmd;
	logic [DATA_W-1:0] head_data;
	logic [DATA_W-1:0] hit_data;

	// Command decode, count and result register.
	pol_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser),
		.position   (s_tdata[5:0]),
		.value      (s_tdata[37:6]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast),
		.cmd        (cmd),
		.head_data  (head_data),
		.hit_data   (hit_data)
	);

	// Entry storage as a row of shifting cells.
	pol_chain #(
		.CAPACITY(CAPACITY)
	) u_chain (
		.clk       (clk),
		.cmd       (cmd),
		.head_data (head_data),
		.hit_data  (hit_data)
	);

endmodule
